FILE: rtl/edh_pkg.sv
// ----------------------------------------------------------------------------
// edh_pkg
// Shared types, widths and constants of the error diffusion halftoner.
// ----------------------------------------------------------------------------
package edh_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 4096;
  localparam int unsigned MAX_REPEAT      = 16;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned REP_W      = 5;
  localparam int unsigned COLUMN_W   = 12;
  localparam int unsigned COLUMN_MAX = 4095;
  localparam int unsigned NCH        = 3;

  // channel slots; grey mode runs in the yellow slot
  localparam int unsigned CH_Y = 0;
  localparam int unsigned CH_M = 1;
  localparam int unsigned CH_C = 2;

  // error arithmetic
  localparam int unsigned ERR_W      = 8;
  localparam int unsigned ERR_XW     = ERR_W + 2;
  localparam int unsigned ERR_DIV    = 8;
  localparam int unsigned ERR_SHIFT  = $clog2(ERR_DIV);
  localparam logic signed [ERR_XW-1:0] ROUND_ADD  = ERR_XW'(4);
  localparam logic signed [ERR_XW-1:0] TRUNC_ADJ  = ERR_XW'(ERR_DIV - 1);
  localparam logic signed [ERR_W-1:0]  DOT_FULL   = ERR_W'(15);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOT_THRESHOLD = 1'b1;
  localparam logic [LEVEL_W-1:0]   THRESHOLD_RST     = 4'd7;

  // command queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [NCH-1:0][ERR_W-1:0] chan_err_t;

  typedef struct packed {
    logic                           colour;
    logic                           row_last;
    logic [REP_W-1:0]               rep;
    logic [NCH-1:0][LEVEL_W-1:0]    level;
  } edh_cmd_t;

  typedef struct packed {
    logic row_end;
    logic pos_zero;
  } edh_back_st_t;

endpackage

FILE: rtl/edh_if.sv
// ----------------------------------------------------------------------------
// edh_pix_if / edh_dot_if
// Valid/ready channels for source pixels and halftone dots.
// ----------------------------------------------------------------------------
interface edh_pix_if;
  import edh_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] yellow_level;
  logic [LEVEL_W-1:0] magenta_level;
  logic [LEVEL_W-1:0] cyan_level;
  logic [LEVEL_W-1:0] black_level;
  logic [REP_W-1:0]   repeat_req;
  logic               row_last;

  modport source (
    output valid, yellow_level, magenta_level, cyan_level, black_level, repeat_req,
           row_last,
    input  ready
  );

  modport sink (
    input  valid, yellow_level, magenta_level, cyan_level, black_level, repeat_req,
           row_last,
    output ready
  );
endinterface

interface edh_dot_if;
  import edh_pkg::*;

  logic                valid;
  logic                ready;
  logic                yellow_dot;
  logic                magenta_dot;
  logic                cyan_dot;
  logic                black_dot;
  logic [COLUMN_W-1:0] column;
  logic                run_last;
  logic                overflow;

  modport source (
    output valid, yellow_dot, magenta_dot, cyan_dot, black_dot, column, run_last,
           overflow,
    input  ready
  );

  modport sink (
    input  valid, yellow_dot, magenta_dot, cyan_dot, black_dot, column, run_last,
           overflow,
    output ready
  );
endinterface

FILE: rtl/error_diffusion_halftoner_4bit.sv
// ----------------------------------------------------------------------------
// error_diffusion_halftoner_4bit
// Error diffusion halftoner for 4-bit pixel levels with horizontal repeat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         transaction
//  pix_i     in   valid/ready       one source pixel, levels and repeat count
//  dot_o     out  valid/ready       one dot per output column
//  cfg_*     in   write enable      colour_mode, dot_threshold
//
//  A pixel of repeat n, clamped to 1..16, yields n columns in the diffusion engine.
//  Pixels wait in a two-entry command queue; a dot waits in the output register.
//  The error row stores need no clearing pass: a per-row fill count makes
//  unwritten entries read as zero, so pixels are taken right after reset.
//  A stalled dot channel holds the engine; intake continues until the queue fills.
// ----------------------------------------------------------------------------
module error_diffusion_halftoner_4bit #(
  parameter int unsigned MAX_COLUMNS = edh_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  edh_pix_if.sink                         pix_i,
  edh_dot_if.source                       dot_o,
  input  logic                            cfg_we_i,
  input  logic [edh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [edh_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import edh_pkg::*;

  localparam int unsigned COL_SAT = (MAX_COLUMNS > COLUMN_MAX) ? COLUMN_MAX : MAX_COLUMNS;

  logic               colour_mode_q;
  logic [LEVEL_W-1:0] dot_threshold_q;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  edh_cmd_t           front_cmd;
  edh_cmd_t           head_cmd;
  edh_back_st_t       back_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_mode_q   <= 1'b0;
      dot_threshold_q <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOUR_MODE: begin
          colour_mode_q <= cfg_data_i[0];
        end
        CFG_DOT_THRESHOLD: begin
          dot_threshold_q <= cfg_data_i[LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  edh_front u_front (
    .pix_i         (pix_i),
    .colour_mode_i (colour_mode_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  edh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  edh_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dot_threshold_i (dot_threshold_q),
    .cmd_valid_i     (q_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (q_pop),
    .dot_o           (dot_o),
    .st_o            (back_st)
  );

  a_row_end_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.row_end |=> back_st.pos_zero)
    else $error("column position not rewound after row end");

  a_mode_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_o.valid |-> !(dot_o.black_dot &&
                      (dot_o.yellow_dot || dot_o.magenta_dot || dot_o.cyan_dot)))
    else $error("black and colour dots in one transaction");

  a_overflow_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_o.valid && dot_o.overflow |-> 32'(dot_o.column) >= COL_SAT)
    else $error("overflow flagged inside the column store");

endmodule

FILE: rtl/edh_front.sv
// ----------------------------------------------------------------------------
// edh_front
// Pixel intake: picks the channel levels for the mode and clamps the repeat.
// ----------------------------------------------------------------------------
module edh_front (
  edh_pix_if.sink            pix_i,
  input  logic               colour_mode_i,
  input  logic               q_full_i,
  output logic               push_o,
  output edh_pkg::edh_cmd_t  cmd_o
);
  import edh_pkg::*;

  assign pix_i.ready = !q_full_i;
  assign push_o      = pix_i.valid && !q_full_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.colour   = colour_mode_i;
    cmd_o.row_last = pix_i.row_last;
    if (colour_mode_i) begin
      cmd_o.level[CH_Y] = pix_i.yellow_level;
      cmd_o.level[CH_M] = pix_i.magenta_level;
      cmd_o.level[CH_C] = pix_i.cyan_level;
    end else begin
      cmd_o.level[CH_Y] = pix_i.black_level;
    end
    if (pix_i.repeat_req == '0) begin
      cmd_o.rep = REP_W'(1);
    end else if (32'(pix_i.repeat_req) > MAX_REPEAT) begin
      cmd_o.rep = REP_W'(MAX_REPEAT);
    end else begin
      cmd_o.rep = pix_i.repeat_req;
    end
  end

endmodule

FILE: rtl/edh_queue.sv
// ----------------------------------------------------------------------------
// edh_queue
// Short command queue between pixel intake and the diffusion engine.
// ----------------------------------------------------------------------------
module edh_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  edh_pkg::edh_cmd_t  cmd_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output edh_pkg::edh_cmd_t  cmd_o
);
  import edh_pkg::*;

  edh_cmd_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q;
  logic [QPTR_W-1:0]  rptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= ptr_next(wptr_q);
      if (do_pop)  rptr_q <= ptr_next(rptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= cmd_i;
  end

endmodule

FILE: rtl/edh_back.sv
// ----------------------------------------------------------------------------
// edh_back
// Diffusion engine: one output column per cycle while not stalled, ping-pong error row stores.
// ----------------------------------------------------------------------------
module edh_back #(
  parameter int unsigned MAX_COLUMNS = edh_pkg::MAX_COLUMNS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [edh_pkg::LEVEL_W-1:0]  dot_threshold_i,
  input  logic                         cmd_valid_i,
  input  edh_pkg::edh_cmd_t            cmd_i,
  output logic                         cmd_pop_o,
  edh_dot_if.source                    dot_o,
  output edh_pkg::edh_back_st_t        st_o
);
  import edh_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_COLUMNS);
  localparam int unsigned POS_W  = $clog2(MAX_COLUMNS + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_COLUMNS);

  typedef struct packed {
    logic             dot;
    logic [ERR_W-1:0] e2;
    logic [ERR_W-1:0] e3;
  } chan_res_t;

  function automatic chan_res_t chan_step(logic [ERR_W-1:0] err, logic [LEVEL_W-1:0] level,
                                          logic [LEVEL_W-1:0] thr);
    logic signed [ERR_XW-1:0] t;
    logic signed [ERR_XW-1:0] q;
    logic signed [ERR_W-1:0]  v;
    logic signed [ERR_W-1:0]  thr_s;
    logic signed [ERR_W-1:0]  e;
    chan_res_t                r;
    t = $signed({{(ERR_XW - ERR_W){err[ERR_W-1]}}, err}) + ROUND_ADD;
    if (t[ERR_XW-1]) t = t + TRUNC_ADJ;
    q     = t >>> ERR_SHIFT;
    v     = q[ERR_W-1:0] + ERR_W'(level);
    thr_s = ERR_W'(thr);
    r.dot = v > thr_s;
    e     = r.dot ? v - DOT_FULL : v;
    r.e2  = {e[ERR_W-2:0], 1'b0};
    r.e3  = r.e2 + e;
    return r;
  endfunction

  // error row stores
  chan_err_t         mem0_q [MAX_COLUMNS];
  chan_err_t         mem1_q [MAX_COLUMNS];
  chan_err_t         rd0_q;
  chan_err_t         rd1_q;
  chan_err_t         byp_data_q;
  logic              byp_q;

  // column state
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  pos_d;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  fill_q;
  logic              sel_q;
  logic [REP_W-1:0]  cnt_q;
  chan_err_t         tail_q;
  chan_err_t         rcar_q;
  chan_err_t         dcar_q;
  chan_err_t         rcar_n;
  chan_err_t         dcar_n;

  // output register
  logic                out_valid_q;
  logic [NCH-1:0]      dots_q;
  logic                black_q;
  logic [COLUMN_W-1:0] col_q;
  logic                run_last_q;
  logic                ovf_q;

  logic              fire;
  logic              last;
  logic              row_end;
  logic              col_ok;
  logic [NCH-1:0]    proc;
  chan_err_t         rd_data;
  chan_err_t         cur_err;
  chan_err_t         err;
  chan_err_t         wr_data;
  chan_res_t         res [NCH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [NCH-1:0]    dots;
  logic [COLUMN_W-1:0] col;

  always_comb begin
    col_ok  = pos_q < POS_MAX;
    proc    = cmd_i.colour ? '1 : NCH'(1);
    last    = cnt_q == cmd_i.rep - REP_W'(1);
    fire    = cmd_valid_i && (!out_valid_q || dot_o.ready);
    row_end = fire && last && cmd_i.row_last;
    rd_data = byp_q ? byp_data_q : (sel_q ? rd1_q : rd0_q);
    for (int ch = 0; ch < NCH; ch++) begin
      if (!col_ok) begin
        cur_err[ch] = '0;
      end else if (pos_q < fill_q) begin
        cur_err[ch] = rd_data[ch];
      end else if (pos_q == fill_q) begin
        cur_err[ch] = tail_q[ch];
      end else begin
        cur_err[ch] = '0;
      end
      err[ch] = col_ok ? cur_err[ch] + rcar_q[ch] : '0;
      res[ch] = chan_step(err[ch], cmd_i.level[ch], dot_threshold_i);
      if (proc[ch]) begin
        rcar_n[ch]  = res[ch].e3;
        dcar_n[ch]  = res[ch].e2;
        wr_data[ch] = dcar_q[ch] + res[ch].e3;
        dots[ch]    = res[ch].dot;
      end else begin
        rcar_n[ch]  = '0;
        dcar_n[ch]  = '0;
        wr_data[ch] = dcar_q[ch];
        dots[ch]    = 1'b0;
      end
    end
    pos_inc = col_ok ? pos_q + POS_W'(1) : pos_q;
    pos_d   = pos_q;
    if (fire) pos_d = row_end ? '0 : pos_inc;
    wr_en   = fire && col_ok;
    wr_addr = pos_q[ADDR_W-1:0];
    rd_addr = pos_d[ADDR_W-1:0];
    if (32'(pos_q) > COLUMN_MAX) begin
      col = COLUMN_W'(COLUMN_MAX);
    end else begin
      col = COLUMN_W'(pos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && sel_q)  mem0_q[wr_addr] <= wr_data;
    if (wr_en && !sel_q) mem1_q[wr_addr] <= wr_data;
    rd0_q      <= mem0_q[rd_addr];
    rd1_q      <= mem1_q[rd_addr];
    byp_q      <= wr_en && row_end && (wr_addr == rd_addr);
    byp_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      sel_q       <= 1'b0;
      cnt_q       <= '0;
      tail_q      <= '0;
      rcar_q      <= '0;
      dcar_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cnt_q       <= last ? '0 : cnt_q + REP_W'(1);
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
        if (row_end) begin
          sel_q  <= !sel_q;
          fill_q <= pos_inc;
          tail_q <= dcar_n;
          rcar_q <= '0;
          dcar_q <= '0;
        end else begin
          rcar_q <= rcar_n;
          dcar_q <= dcar_n;
        end
      end else if (dot_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dots_q     <= cmd_i.colour ? dots : '0;
      black_q    <= cmd_i.colour ? 1'b0 : dots[CH_Y];
      col_q      <= col;
      run_last_q <= last;
      ovf_q      <= !col_ok;
    end
  end

  assign cmd_pop_o         = fire && last;
  assign dot_o.valid       = out_valid_q;
  assign dot_o.yellow_dot  = dots_q[CH_Y];
  assign dot_o.magenta_dot = dots_q[CH_M];
  assign dot_o.cyan_dot    = dots_q[CH_C];
  assign dot_o.black_dot   = black_q;
  assign dot_o.column      = col_q;
  assign dot_o.run_last    = run_last_q;
  assign dot_o.overflow    = ovf_q;

  assign st_o.row_end  = row_end;
  assign st_o.pos_zero = pos_q == '0;

endmodule

FILE: sim/edh_dot_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edh_dot_checker
// Watches the pixel, dot and configuration ports of the halftoner, predicts
// every dot from its own copy of the error rows and compares field by field.
// ----------------------------------------------------------------------------
module edh_dot_checker #(
  parameter int unsigned MAX_COLS = edh_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  edh_pix_if                              pix_i,
  edh_dot_if                              dot_i,
  input  logic                            cfg_we_i,
  input  logic [edh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [edh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              dots_due_o,
  output int                              fail_cnt_o
);
  import edh_pkg::*;

  localparam int ROUND_OFS    = 4;
  localparam int ERR_DIVISOR  = 8;
  localparam int FULL_DOT     = 15;

  typedef struct packed {
    logic                y;
    logic                m;
    logic                c;
    logic                k;
    logic [COLUMN_W-1:0] column;
    logic                run_last;
    logic                overflow;
  } dot_t;

  dot_t               dots_due [$];
  byte                cur_err [0:MAX_COLS][0:NCH-1];
  byte                nxt_err [0:MAX_COLS][0:NCH-1];
  int                 col_pos;
  logic               colour_q;
  logic [LEVEL_W-1:0] thresh_q;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fail_cnt_o++;
  endtask

  function automatic logic diffuse_channel(input int ch, input int pos, input bit in_store,
                                           input int level);
    int   err;
    int   v;
    int   e;
    int   e2;
    int   e3;
    logic dot;
    err = in_store ? int'(cur_err[pos][ch]) : 0;
    v   = int'(byte'((err + ROUND_OFS) / ERR_DIVISOR + level));
    dot = v > int'(thresh_q);
    e   = dot ? v - FULL_DOT : v;
    e2  = int'(byte'(e * 2));
    e3  = int'(byte'(e2 + e));
    if (in_store) begin
      nxt_err[pos][ch]     = byte'(int'(nxt_err[pos][ch]) + e3);
      nxt_err[pos + 1][ch] = byte'(e2);
      cur_err[pos + 1][ch] = byte'(int'(cur_err[pos + 1][ch]) + e3);
    end
    return dot;
  endfunction

  task automatic clear_rows();
    for (int i = 0; i <= MAX_COLS; i++) begin
      for (int ch = 0; ch < NCH; ch++) begin
        cur_err[i][ch] = 0;
        nxt_err[i][ch] = 0;
      end
    end
  endtask

  task automatic predict_pixel();
    int   n;
    int   k;
    int   pos;
    bit   in_store;
    dot_t d;
    n = int'(pix_i.repeat_req);
    if (n == 0) n = 1;
    if (n > int'(MAX_REPEAT)) n = int'(MAX_REPEAT);
    for (k = 0; k < n; k++) begin
      pos      = col_pos;
      in_store = pos < int'(MAX_COLS);
      d        = '0;
      if (colour_q) begin
        d.y = diffuse_channel(CH_Y, pos, in_store, int'(pix_i.yellow_level));
        d.m = diffuse_channel(CH_M, pos, in_store, int'(pix_i.magenta_level));
        d.c = diffuse_channel(CH_C, pos, in_store, int'(pix_i.cyan_level));
      end else begin
        d.k = diffuse_channel(CH_Y, pos, in_store, int'(pix_i.black_level));
      end
      d.column   = (pos > int'(COLUMN_MAX)) ? COLUMN_W'(COLUMN_MAX) : COLUMN_W'(pos);
      d.run_last = (k == n - 1);
      d.overflow = !in_store;
      dots_due.push_back(d);
      if (col_pos < int'(MAX_COLS)) col_pos++;
    end
    if (pix_i.row_last) begin
      for (int i = 0; i <= MAX_COLS; i++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          cur_err[i][ch] = nxt_err[i][ch];
          nxt_err[i][ch] = 0;
        end
      end
      col_pos = 0;
    end
  endtask

  task automatic check_dot();
    dot_t want;
    if (dots_due.size() == 0) begin
      report_mismatch("unexpected dot at column", 16'(dot_i.column), 16'hffff);
      return;
    end
    want = dots_due.pop_front();
    if (dot_i.yellow_dot !== want.y)
      report_mismatch("yellow_dot", 16'(dot_i.yellow_dot), 16'(want.y));
    if (dot_i.magenta_dot !== want.m)
      report_mismatch("magenta_dot", 16'(dot_i.magenta_dot), 16'(want.m));
    if (dot_i.cyan_dot !== want.c)
      report_mismatch("cyan_dot", 16'(dot_i.cyan_dot), 16'(want.c));
    if (dot_i.black_dot !== want.k)
      report_mismatch("black_dot", 16'(dot_i.black_dot), 16'(want.k));
    if (dot_i.column !== want.column)
      report_mismatch("column", 16'(dot_i.column), 16'(want.column));
    if (dot_i.run_last !== want.run_last)
      report_mismatch("run_last", 16'(dot_i.run_last), 16'(want.run_last));
    if (dot_i.overflow !== want.overflow)
      report_mismatch("overflow", 16'(dot_i.overflow), 16'(want.overflow));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_rows();
      dots_due.delete();
      col_pos    = 0;
      colour_q   = 1'b0;
      thresh_q   = THRESHOLD_RST;
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLOUR_MODE: begin
            colour_q = cfg_data_i[0];
          end
          CFG_DOT_THRESHOLD: begin
            thresh_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (dot_i.valid && dot_i.ready) check_dot();
      if (pix_i.valid && pix_i.ready) predict_pixel();
    end
    dots_due_o = dots_due.size();
  end

endmodule

FILE: sim/tb_error_diffusion_halftoner_4bit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_error_diffusion_halftoner_4bit
// Drives pixels and configuration into the halftoner with random idling on
// both channels: a directed run over levels, repeats, modes and row ends, a
// row long enough to overflow the error store, then random phases under
// several settings. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_error_diffusion_halftoner_4bit;
  import edh_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASE_ITEMS   = 8;
  localparam int PHASES        = 6;
  localparam int LONG_ROW_COLS = MAX_COLUMNS_DEF + 40;

  typedef struct packed {
    logic [LEVEL_W-1:0] y;
    logic [LEVEL_W-1:0] m;
    logic [LEVEL_W-1:0] c;
    logic [LEVEL_W-1:0] k;
    logic [REP_W-1:0]   rep;
    logic               last;
  } pixel_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    dots_due;
  int                    fail_cnt;
  int                    hold_reqs    = 0;
  int                    tx_calm_left = 0;
  int                    cycle_cnt    = 0;

  edh_pix_if pix_if ();
  edh_dot_if dot_if ();

  error_diffusion_halftoner_4bit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .dot_o      (dot_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  edh_dot_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_if),
    .dot_i      (dot_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .dots_due_o (dots_due),
    .fail_cnt_o (fail_cnt)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return LEVEL_W'($urandom_range(0, 15));
  endfunction

  function automatic pixel_t make_pixel(input int y, input int m, input int c, input int k,
                                        input int rep, input bit last);
    pixel_t p;
    p.y    = LEVEL_W'(y);
    p.m    = LEVEL_W'(m);
    p.c    = LEVEL_W'(c);
    p.k    = LEVEL_W'(k);
    p.rep  = REP_W'(rep);
    p.last = last;
    return p;
  endfunction

  function automatic pixel_t rand_pixel(input bit last);
    pixel_t p;
    int     r;
    r = $urandom_range(0, 99);
    p = make_pixel(rand_level(), rand_level(), rand_level(), rand_level(), 0, last);
    if (r < 60) p.rep = REP_W'($urandom_range(0, 4));
    else if (r < 85) p.rep = REP_W'($urandom_range(5, 16));
    else p.rep = REP_W'($urandom_range(17, 31));
    return p;
  endfunction

  task automatic push_pixel(input pixel_t p);
    pix_if.valid         <= 1'b1;
    pix_if.yellow_level  <= p.y;
    pix_if.magenta_level <= p.m;
    pix_if.cyan_level    <= p.c;
    pix_if.black_level   <= p.k;
    pix_if.repeat_req    <= p.rep;
    pix_if.row_last      <= p.last;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
  endtask

  task automatic pause_tx();
    int n;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
      n = 0;
    end else begin
      n = idle_gap();
      if ($urandom_range(0, 29) == 0) tx_calm_left = $urandom_range(10, 40);
    end
    if (n > 0) begin
      pix_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send(input pixel_t p);
    push_pixel(p);
    pause_tx();
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (dots_due == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input bit colour, input int thresh);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_COLOUR_MODE;
    cfg_data <= CFG_DATA_W'(colour);
    @(posedge clk_i);
    cfg_idx  <= CFG_DOT_THRESHOLD;
    cfg_data <= CFG_DATA_W'(thresh);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // dot receiver: random stalls, calm stretches, and long holds on request
  initial begin : dot_sink
    int gap_left;
    int calm_left;
    int hold_left;
    int holds_done;
    gap_left     = 0;
    calm_left    = 0;
    hold_left    = 0;
    holds_done   = 0;
    dot_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_reqs) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dot_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        dot_if.ready <= 1'b0;
      end else begin
        dot_if.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
        else gap_left = idle_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t p;
    int     cols;
    pix_if.valid         = 1'b0;
    pix_if.yellow_level  = '0;
    pix_if.magenta_level = '0;
    pix_if.cyan_level    = '0;
    pix_if.black_level   = '0;
    pix_if.repeat_req    = '0;
    pix_if.row_last      = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CFG_COLOUR_MODE;
    cfg_data             = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // grey mode at reset settings: extremes, zero and oversize repeat
    send(make_pixel(0, 0, 0, 0, 1, 1'b0));
    send(make_pixel(0, 0, 0, 15, 1, 1'b0));
    send(make_pixel(3, 3, 3, 8, 0, 1'b0));
    send(make_pixel(0, 0, 0, 7, 31, 1'b0));
    send(make_pixel(15, 15, 15, 9, 16, 1'b1));
    drain();
    set_config(1'b1, 0);
    send(make_pixel(15, 0, 8, 0, 3, 1'b0));
    send(make_pixel(0, 15, 1, 15, 5, 1'b0));
    send(make_pixel(8, 8, 8, 0, 2, 1'b1));
    drain();
    set_config(1'b1, 15);
    send(make_pixel(15, 15, 15, 0, 4, 1'b0));
    send(make_pixel(0, 0, 0, 15, 1, 1'b0));
    // switch mode in the middle of a row
    drain();
    set_config(1'b0, 15);
    send(make_pixel(0, 0, 0, 15, 2, 1'b0));
    send(make_pixel(15, 15, 15, 1, 0, 1'b1));
    drain();
    set_config(1'b0, 0);
    send(make_pixel(0, 0, 0, 0, 2, 1'b0));
    send(make_pixel(0, 0, 0, 15, 17, 1'b1));
    drain();

    // row past the end of the error store
    set_config(1'b1, 7);
    cols = 0;
    while (cols < LONG_ROW_COLS) begin
      p     = rand_pixel(1'b0);
      p.rep = REP_W'($urandom_range(16, 31));
      cols += (int'(p.rep) > int'(MAX_REPEAT)) ? int'(MAX_REPEAT) : int'(p.rep);
      send(p);
    end
    send(rand_pixel(1'b1));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          set_config(1'b1, 7);
        end
        1: begin
          set_config(1'b0, 0);
        end
        2: begin
          set_config(1'b1, 15);
        end
        3: begin
          set_config(1'b0, 15);
        end
        4: begin
          set_config(1'b1, 0);
        end
        default: begin
          set_config(1'(($urandom_range(0, 1))), $urandom_range(0, 15));
        end
      endcase
      if (ph == 0) begin
        // hold the dot side while pixels keep coming
        hold_reqs++;
        tx_calm_left = 60;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send(rand_pixel($urandom_range(0, 9) == 0));
      end
      drain();
    end

    if (fail_cnt == 0 && dots_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
